/* hdl/crcf_pkg.sv */
package crcf_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_OPEN = 8'h28;

  // CRC-16 (0x1021) advanced by one nibble: entry i is i times the polynomial
  localparam logic [15:0] NIB_TABLE [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
    16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
    logic [3:0] idx;
    idx = crc[15:12] ^ nib;
    return {crc[11:0], 4'h0} ^ NIB_TABLE[idx];
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] mid;
    mid = crc_nibble(crc, b[7:4]);
    return crc_nibble(mid, b[3:0]);
  endfunction

  // CRC bytes that look like a delimiter go out bumped by one
  function automatic logic [7:0] escape_byte(input logic [7:0] b);
    if (b == CHAR_OPEN || b == CHAR_CR || b == CHAR_LF) begin
      return b + 8'd1;
    end
    return b;
  endfunction

endpackage

/* hdl/crcf_ifs.sv */
interface crcf_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_command;

  modport source (output valid, output data_byte, output end_of_command, input ready);
  modport sink (input valid, input data_byte, input end_of_command, output ready);
endinterface

interface crcf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_done;

  modport source (output valid, output tx_byte, output frame_done, input ready);
  modport sink (input valid, input tx_byte, input frame_done, output ready);
endinterface

/* hdl/crc16_command_framer_unit.sv */
// Command framer: every byte on cmd leaves on tx unchanged, one beat per cycle unless tx
// stalls or a trailer is owed, while a CRC-16 (poly 0x1021, init 0, MSB first) runs
// over it. A byte with end_of_command set is followed by three more tx beats: CRC high,
// CRC low (each bumped by one if it equals 0x28, 0x0D or 0x0A) and a CR with frame_done
// set; the CRC then restarts at zero. After a last byte the output sequencer emits the
// trailer before it takes the next staged byte. Data passes from cmd to tx through one
// input register and one output register.
module crc16_command_framer_unit (
  input  logic       clk,
  input  logic       rst,
  crcf_cmd_if.sink   cmd,
  crcf_tx_if.source  tx
);

  logic            stage_valid;
  crcf_pkg::item_t stage;
  logic            take;
  logic [15:0]     crc_full;

  crcf_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  crcf_crc u_crc (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .stage    (stage),
    .crc_full (crc_full)
  );

  crcf_tx u_tx (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .crc_full    (crc_full),
    .take        (take),
    .tx          (tx)
  );

endmodule

/* hdl/crcf_in_reg.sv */
module crcf_in_reg (
  input  logic            clk,
  input  logic            rst,
  crcf_cmd_if.sink        cmd,
  input  logic            take,
  output logic            stage_valid,
  output crcf_pkg::item_t stage
);

  assign cmd.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      stage.data <= cmd.data_byte;
      stage.last <= cmd.end_of_command;
    end
  end

endmodule

/* hdl/crcf_crc.sv */
module crcf_crc (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  crcf_pkg::item_t stage,
  output logic [15:0]     crc_full
);

  logic [15:0] running_crc;

  // CRC including the staged byte
  assign crc_full = crcf_pkg::crc_byte(running_crc, stage.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (take) begin
      running_crc <= stage.last ? 16'h0000 : crc_full;
    end
  end

endmodule

/* hdl/crcf_tx.sv */
module crcf_tx (
  input  logic            clk,
  input  logic            rst,
  input  logic            stage_valid,
  input  crcf_pkg::item_t stage,
  input  logic [15:0]     crc_full,
  output logic            take,
  crcf_tx_if.source       tx
);

  // state names the next trailer beat still owed; ST_DATA means none
  typedef enum logic [1:0] {ST_DATA, ST_HI, ST_LO, ST_CR} state_t;

  state_t     state;
  logic [7:0] crc_hi;
  logic [7:0] crc_lo;
  logic       advance;

  assign advance = !tx.valid || tx.ready;
  assign take    = advance && (state == ST_DATA) && stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_DATA;
      tx.valid <= 1'b0;
    end else if (advance) begin
      unique case (state)
        ST_DATA: begin
          tx.valid      <= stage_valid;
          tx.tx_byte    <= stage.data;
          tx.frame_done <= 1'b0;
          if (stage_valid && stage.last) begin
            crc_hi <= crcf_pkg::escape_byte(crc_full[15:8]);
            crc_lo <= crcf_pkg::escape_byte(crc_full[7:0]);
            state  <= ST_HI;
          end
        end
        ST_HI: begin
          tx.valid      <= 1'b1;
          tx.tx_byte    <= crc_hi;
          tx.frame_done <= 1'b0;
          state         <= ST_LO;
        end
        ST_LO: begin
          tx.valid      <= 1'b1;
          tx.tx_byte    <= crc_lo;
          tx.frame_done <= 1'b0;
          state         <= ST_CR;
        end
        ST_CR: begin
          tx.valid      <= 1'b1;
          tx.tx_byte    <= crcf_pkg::CHAR_CR;
          tx.frame_done <= 1'b1;
          state         <= ST_DATA;
        end
        default: begin
          state <= ST_DATA;
        end
      endcase
    end
  end

endmodule

/* hdl/crcf_checker.sv */
module crcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       cmd_last,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_byte,
  input logic       tx_done
);

  // frames whose end mark went in but whose CR has not come out
  logic [2:0] open_frames;
  logic       last_in;
  logic       done_out;

  assign last_in  = cmd_valid && cmd_ready && cmd_last;
  assign done_out = tx_valid && tx_ready && tx_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_frames <= '0;
    end else begin
      open_frames <= open_frames + {2'b00, last_in} - {2'b00, done_out};
    end
  end

  a_done_is_cr: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_done |-> tx_byte == crcf_pkg::CHAR_CR)
    else $error("frame_done on a byte other than CR");

  a_done_has_frame: assert property (@(posedge clk) disable iff (rst)
    done_out |-> open_frames != 3'd0)
    else $error("frame closed with no end mark taken");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !tx_valid)
    else $error("tx valid right after reset");

  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_done))
    else $error("stalled tx beat changed");

endmodule

bind crc16_command_framer_unit crcf_checker u_crcf_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_last  (cmd.end_of_command),
  .tx_valid  (tx.valid),
  .tx_ready  (tx.ready),
  .tx_byte   (tx.tx_byte),
  .tx_done   (tx.frame_done)
);
